/* hw/rtl/tlbs_pkg.sv */
// Shared types, constants and register codes of the text line and block segmenter.
`default_nettype none

package tlbs_pkg;

  // Widths of indices and coordinates.
  localparam int INDEX_WIDTH = 16;
  localparam int COORD_WIDTH = 24;
  localparam int CP_WIDTH    = 21;

  // Line break code points.
  localparam logic [CP_WIDTH-1:0] CP_LINE_FEED = 21'd10;
  localparam logic [CP_WIDTH-1:0] CP_CARR_RET  = 21'd13;

  // Configuration port.
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 11;
  localparam int SAME_W         = 9;
  localparam int GAP_W          = 11;

  localparam logic [SAME_W-1:0] SAME_RESET = 9'd128;
  localparam logic [GAP_W-1:0]  GAP_RESET  = 11'd192;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_SAME_LINE = 2'd0,
    CFG_BLOCK_GAP = 2'd1
  } cfg_idx_e;

  // Stream packing: input tdata, code point first, then left, right, bottom, top.
  localparam int S_TUSER_WIDTH = 2;
  localparam int M_TDATA_WIDTH = 2 * INDEX_WIDTH;
  localparam int CP_LSB        = 0;
  localparam int LEFT_LSB      = CP_LSB + CP_WIDTH;
  localparam int RIGHT_LSB     = LEFT_LSB + COORD_WIDTH;
  localparam int BOTTOM_LSB    = RIGHT_LSB + COORD_WIDTH;
  localparam int TOP_LSB       = BOTTOM_LSB + COORD_WIDTH;
  localparam int PACK_END      = TOP_LSB + COORD_WIDTH;
  localparam int S_TDATA_WIDTH = ((PACK_END + 7) / 8) * 8;

  // Input tuser bits.
  localparam int USER_FIRST = 0;
  localparam int USER_FOUND = 1;

  // Width of the exact ratio products and their compare.
  localparam int PROD_WIDTH = COORD_WIDTH + 13;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic                first_of_page;
    logic [CP_WIDTH-1:0] code_point;
    logic                box_found;
    coord_t              edge_left;
    coord_t              edge_right;
    coord_t              edge_bottom;
    coord_t              edge_top;
  } item_t;

  typedef struct packed {
    coord_t                 line_top;
    coord_t                 line_bottom;
    logic                   line_has_box;
    logic                   break_pending;
    logic [INDEX_WIDTH-1:0] line_counter;
    logic [INDEX_WIDTH-1:0] block_counter;
  } state_t;

  typedef struct packed {
    logic [SAME_W-1:0] same_line_ratio_q8;
    logic [GAP_W-1:0]  block_gap_ratio_q8;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/tlbs_cfg.sv */
// Configuration registers of the segmenter: the two ratio settings.
`default_nettype none

module tlbs_cfg
  import tlbs_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data_i,
  output cfg_t                           cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Write decode; unknown indices are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SAME_LINE: cfg_d.same_line_ratio_q8 = cfg_data_i[SAME_W-1:0];
        CFG_BLOCK_GAP: cfg_d.block_gap_ratio_q8 = cfg_data_i[GAP_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.same_line_ratio_q8 <= SAME_RESET;
      cfg_q.block_gap_ratio_q8 <= GAP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/tlbs_decide.sv */
// Per-character decision: normalizes the box, tests line and block breaks, updates line state.
`default_nettype none

module tlbs_decide
  import tlbs_pkg::*;
(
  input  item_t  item_i,
  input  state_t st_i,
  input  cfg_t   cfg_i,
  output state_t st_o
);

  typedef logic signed [COORD_WIDTH:0] diff_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  state_t st_base;
  coord_t cbot, ctop, ov_top, ov_bot;
  diff_t  ch, lh, mh, overlap, gap;
  prod_t  ov_scaled, same_lim, gap_scaled, gap_lim;
  logic   degenerate, is_break, pend, low_overlap, wide_gap, new_line;

  // Normalized box and degenerate test.
  always_comb begin
    cbot = (item_i.edge_bottom < item_i.edge_top) ? item_i.edge_bottom : item_i.edge_top;
    ctop = (item_i.edge_bottom < item_i.edge_top) ? item_i.edge_top : item_i.edge_bottom;
    degenerate = !item_i.box_found || (item_i.edge_left == item_i.edge_right) ||
                 (item_i.edge_bottom == item_i.edge_top);
    is_break = (item_i.code_point == CP_LINE_FEED) || (item_i.code_point == CP_CARR_RET);
  end

  // State after an optional page clear.
  always_comb begin
    st_base = st_i;
    if (item_i.first_of_page) begin
      st_base = '0;
    end
    pend = st_base.break_pending || is_break;
  end

  // Exact ratio tests on heights, overlap and gap.
  always_comb begin
    ch      = diff_t'(ctop) - diff_t'(cbot);
    lh      = diff_t'(st_base.line_top) - diff_t'(st_base.line_bottom);
    mh      = (lh < ch) ? lh : ch;
    ov_top  = (st_base.line_top < ctop) ? st_base.line_top : ctop;
    ov_bot  = (st_base.line_bottom > cbot) ? st_base.line_bottom : cbot;
    overlap = diff_t'(ov_top) - diff_t'(ov_bot);
    gap     = diff_t'(st_base.line_bottom) - diff_t'(ctop);

    ov_scaled  = prod_t'(overlap) <<< 8;
    same_lim   = prod_t'($signed({1'b0, cfg_i.same_line_ratio_q8})) * prod_t'(mh);
    gap_scaled = prod_t'(gap) <<< 8;
    gap_lim    = prod_t'($signed({1'b0, cfg_i.block_gap_ratio_q8})) * prod_t'(ch);

    low_overlap = ov_scaled < same_lim;
    wide_gap    = gap_scaled > gap_lim;
    new_line    = pend || (st_base.line_has_box && low_overlap);
  end

  // Next line state and saturating indices.
  always_comb begin
    st_o = st_base;
    st_o.break_pending = pend;
    if (!degenerate) begin
      if (new_line && st_base.line_has_box) begin
        if (st_base.line_counter != '1) begin
          st_o.line_counter = st_base.line_counter + INDEX_WIDTH'(1);
        end
        if (wide_gap && (st_base.block_counter != '1)) begin
          st_o.block_counter = st_base.block_counter + INDEX_WIDTH'(1);
        end
        st_o.line_top    = ctop;
        st_o.line_bottom = cbot;
      end else if (st_base.line_has_box) begin
        st_o.line_top    = (st_base.line_top > ctop) ? st_base.line_top : ctop;
        st_o.line_bottom = (st_base.line_bottom < cbot) ? st_base.line_bottom : cbot;
      end else begin
        st_o.line_top    = ctop;
        st_o.line_bottom = cbot;
      end
      st_o.line_has_box  = 1'b1;
      st_o.break_pending = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/text_line_block_segmenter.sv */
// A character beat passes through the input register, then the result register, and leaves
// as a result beat. Throughput: one character per cycle while results are not stalled; the
// line state loop closes through the decision logic (one 11x25 and one 9x25 product with
// their compares). Input register and result register each hold one beat, so one more
// input beat is taken while a result is stalled. Reset clears line state and indices and
// loads the ratio registers with their defaults; no clearing pass is needed.
`default_nettype none

module text_line_block_segmenter
  import tlbs_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Config write port.
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data_i,
  // Character stream.
  input  wire logic                      s_axis_tvalid,
  output      logic                      s_axis_tready,
  // tdata: code_point, edge_left, edge_right, edge_bottom, edge_top, zero fill.
  input  wire logic [S_TDATA_WIDTH-1:0]  s_axis_tdata,
  // tuser: first_of_page, box_found.
  input  wire logic [S_TUSER_WIDTH-1:0]  s_axis_tuser,
  // Result stream.
  output      logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // tdata: line_number, block_number.
  output      logic [M_TDATA_WIDTH-1:0]  m_axis_tdata
);

  cfg_t   cfg;
  item_t  in_item_q, in_item_d;
  state_t st_q, st_next;
  logic   in_valid_q, in_valid_d, out_valid_q, out_valid_d, advance;
  logic [INDEX_WIDTH-1:0] out_line_q, out_block_q;

  tlbs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tlbs_decide u_decide (
    .item_i (in_item_q),
    .st_i   (st_q),
    .cfg_i  (cfg),
    .st_o   (st_next)
  );

  // Beat flow between input register and result register.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  // Unpack the incoming beat.
  always_comb begin
    in_item_d.first_of_page = s_axis_tuser[USER_FIRST];
    in_item_d.box_found     = s_axis_tuser[USER_FOUND];
    in_item_d.code_point    = s_axis_tdata[CP_LSB +: CP_WIDTH];
    in_item_d.edge_left     = s_axis_tdata[LEFT_LSB +: COORD_WIDTH];
    in_item_d.edge_right    = s_axis_tdata[RIGHT_LSB +: COORD_WIDTH];
    in_item_d.edge_bottom   = s_axis_tdata[BOTTOM_LSB +: COORD_WIDTH];
    in_item_d.edge_top      = s_axis_tdata[TOP_LSB +: COORD_WIDTH];
  end

  // Control and line state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance && in_valid_q) begin
        st_q <= st_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= in_item_d;
    end
    if (advance && in_valid_q) begin
      out_line_q  <= st_next.line_counter;
      out_block_q <= st_next.block_counter;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_block_q, out_line_q};

endmodule

`default_nettype wire

/* hw/rtl/tlbs_checker.sv */
// Port-level checks of the segmenter, bound to the top level.
`default_nettype none

module tlbs_checker
  import tlbs_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [M_TDATA_WIDTH-1:0]  m_axis_tdata
);

  // A stalled result beat stays and holds its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // A fresh result follows a character beat that was taken and passed through the input register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without matching character beat");

  // Input back-pressure only while both registers are full and the sink stalls.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked result");

  // A block never starts without a new line, so block index stays at or below line index.
  a_block_le_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH] <=
                      m_axis_tdata[INDEX_WIDTH-1:0])
    else $error("block index above line index");

endmodule

bind text_line_block_segmenter tlbs_checker u_tlbs_checker (.*);

`default_nettype wire
